// File: hdl/rom_image_loader_parser_assert.svh
// assertion macros for the rom image loader parser
// used by the top level; expects clk and arst_n in scope
`ifndef ROM_IMAGE_LOADER_PARSER_ASSERT_SVH
`define ROM_IMAGE_LOADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define RILP_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`define RILP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define RILP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RILP_ASSERT_NEVER(lbl, expr, msg)
`define RILP_ASSERT_IMPLY(lbl, ante, cons, msg)
`define RILP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/rilp_pkg.sv
// shared types and constants of the rom image loader parser
// no dependencies
package rilp_pkg;

	typedef enum logic [3:0] {
		PH_HDR1     = 4'd0,
		PH_SECT1    = 4'd1,
		PH_DADDR_HI = 4'd2,
		PH_DADDR_LO = 4'd3,
		PH_DTYPE    = 4'd4,
		PH_DNUM     = 4'd5,
		PH_DSTR     = 4'd6,
		PH_HDR2     = 4'd7,
		PH_SECT2    = 4'd8,
		PH_CADDR_HI = 4'd9,
		PH_CADDR_LO = 4'd10,
		PH_CBODY    = 4'd11,
		PH_DRAIN    = 4'd12
	} phase_t;

	localparam logic [7:0] SEC_DATA = 8'h00;
	localparam logic [7:0] SEC_CODE = 8'h01;
	localparam logic [7:0] TYPE_NUM = 8'h02;
	localparam logic [7:0] TYPE_STR = 8'h01;
	localparam logic [7:0] STR_END  = 8'h00;
	localparam logic [1:0] HDR_LAST = 2'd3;

	typedef struct packed {
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        done;
		logic        err;
	} beat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		phase_t phase;
		logic   err;
	} front_stat_t;

	function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = 8'hff;
			2'd1: b = 8'hfe;
			2'd2: b = 8'hfe;
			default: b = 8'hff;
		endcase
		return b;
	endfunction

endpackage

// File: hdl/rilp_fifo.sv
// short queue of result beats between parser front and output back
// depends on rilp_pkg
module rilp_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rilp_pkg::beat_t push_beat,
	input  logic            pop,
	output rilp_pkg::beat_t head_beat,
	output rilp_pkg::q_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rilp_pkg::beat_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;
	assign head_beat = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/rilp_front.sv
// parser front: accepts image bytes, tracks the format and builds result beats
// depends on rilp_pkg
module rilp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rom_byte,
	input  logic                  last_byte,
	input  logic                  q_full,
	output logic                  push,
	output rilp_pkg::beat_t       push_beat,
	output rilp_pkg::front_stat_t stat
);

	rilp_pkg::phase_t phase_q, phase_d;
	logic [1:0]  hdr_pos_q, hdr_pos_d;
	logic [7:0]  addr_hi_q, addr_hi_d;
	logic [15:0] cur_addr_q, cur_addr_d;
	logic        err_q, err_d;
	logic        accept;
	logic        wv, ok_end;
	logic [7:0]  wd;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign stat.phase = phase_q;
	assign stat.err = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rilp_pkg::PH_HDR1;
			hdr_pos_q  <= '0;
			addr_hi_q  <= '0;
			cur_addr_q <= '0;
			err_q      <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			hdr_pos_q  <= hdr_pos_d;
			addr_hi_q  <= addr_hi_d;
			cur_addr_q <= cur_addr_d;
			err_q      <= err_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		hdr_pos_d  = hdr_pos_q;
		addr_hi_d  = addr_hi_q;
		cur_addr_d = cur_addr_q;
		err_d      = err_q;
		wv         = 1'b0;
		wd         = rom_byte;
		ok_end     = 1'b0;
		case (phase_q)
			rilp_pkg::PH_HDR1, rilp_pkg::PH_HDR2: begin
				if (rom_byte != rilp_pkg::hdr_byte(hdr_pos_q)) begin
					err_d   = 1'b1;
					phase_d = rilp_pkg::PH_DRAIN;
				end else if (hdr_pos_q == rilp_pkg::HDR_LAST) begin
					hdr_pos_d = '0;
					phase_d = (phase_q == rilp_pkg::PH_HDR1) ? rilp_pkg::PH_SECT1
						: rilp_pkg::PH_SECT2;
				end else begin
					hdr_pos_d = hdr_pos_q + 2'd1;
				end
			end
			rilp_pkg::PH_SECT1: begin
				if (rom_byte == rilp_pkg::SEC_DATA) begin
					phase_d = rilp_pkg::PH_DADDR_HI;
				end else if (rom_byte == rilp_pkg::SEC_CODE) begin
					phase_d = rilp_pkg::PH_CADDR_HI;
				end else begin
					err_d   = 1'b1;
					phase_d = rilp_pkg::PH_DRAIN;
				end
			end
			rilp_pkg::PH_DADDR_HI: begin
				addr_hi_d = rom_byte;
				phase_d   = rilp_pkg::PH_DADDR_LO;
			end
			rilp_pkg::PH_DADDR_LO: begin
				cur_addr_d = {addr_hi_q, rom_byte};
				phase_d    = rilp_pkg::PH_DTYPE;
			end
			rilp_pkg::PH_DTYPE: begin
				if (rom_byte == rilp_pkg::TYPE_NUM) begin
					phase_d = rilp_pkg::PH_DNUM;
				end else if (rom_byte == rilp_pkg::TYPE_STR) begin
					phase_d = rilp_pkg::PH_DSTR;
				end else begin
					hdr_pos_d = '0;
					phase_d   = rilp_pkg::PH_HDR2;
				end
			end
			rilp_pkg::PH_DNUM: begin
				wv      = 1'b1;
				phase_d = rilp_pkg::PH_DADDR_HI;
			end
			rilp_pkg::PH_DSTR: begin
				if (rom_byte == rilp_pkg::STR_END) begin
					phase_d = rilp_pkg::PH_DADDR_HI;
				end else if (!last_byte) begin
					wv         = 1'b1;
					cur_addr_d = cur_addr_q + 16'd1;
				end
			end
			rilp_pkg::PH_SECT2: begin
				if (rom_byte == rilp_pkg::SEC_CODE) begin
					phase_d = rilp_pkg::PH_CADDR_HI;
				end else begin
					err_d   = 1'b1;
					phase_d = rilp_pkg::PH_DRAIN;
				end
			end
			rilp_pkg::PH_CADDR_HI: begin
				addr_hi_d = rom_byte;
				phase_d   = rilp_pkg::PH_CADDR_LO;
			end
			rilp_pkg::PH_CADDR_LO: begin
				cur_addr_d = {addr_hi_q, rom_byte};
				phase_d    = rilp_pkg::PH_CBODY;
				ok_end     = 1'b1;
			end
			rilp_pkg::PH_CBODY: begin
				wv         = 1'b1;
				cur_addr_d = cur_addr_q + 16'd1;
				ok_end     = 1'b1;
			end
			default: begin
				err_d   = 1'b1;
				phase_d = rilp_pkg::PH_DRAIN;
			end
		endcase

		push_beat.wr   = wv;
		push_beat.addr = wv ? cur_addr_q : 16'd0;
		push_beat.data = wv ? wd : 8'd0;
		push_beat.done = last_byte;
		push_beat.err  = last_byte && !(ok_end && !err_q);
		push = accept && (wv || last_byte);

		if (last_byte) begin
			phase_d    = rilp_pkg::PH_HDR1;
			hdr_pos_d  = '0;
			addr_hi_d  = '0;
			cur_addr_d = '0;
			err_d      = 1'b0;
		end
	end

endmodule

// File: hdl/rilp_back.sv
// output back end: takes beats from the queue into the result register
// depends on rilp_pkg
module rilp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rilp_pkg::beat_t   head_beat,
	input  rilp_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              write_valid,
	output logic [15:0]       write_address,
	output logic [7:0]        write_data,
	output logic              image_done,
	output logic              status
);

	logic            out_valid_q;
	rilp_pkg::beat_t out_beat_q;

	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_beat_q <= head_beat;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_valid   = out_beat_q.wr;
	assign write_address = out_beat_q.addr;
	assign write_data    = out_beat_q.data;
	assign image_done    = out_beat_q.done;
	assign status        = out_beat_q.err;

endmodule

// File: hdl/rom_image_loader_parser.sv
// rom image loader parser top: front parser, result queue, output register
// bytes are parsed combinationally, beats pushed into the queue, then popped into the
// output register; 1 byte per cycle sustained while in_stall is low, set by the parser
// state update in the front; in_stall rises only when the result queue is full under
// output back pressure; arst_n clears parser state, queue pointers and output valid at once
`include "rom_image_loader_parser_assert.svh"
module rom_image_loader_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rom_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_valid,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic        image_done,
	output logic        status
);

	logic                  push, pop;
	rilp_pkg::beat_t       push_beat, head_beat;
	rilp_pkg::q_stat_t     q_stat;
	rilp_pkg::front_stat_t f_stat;

	rilp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rom_byte  (rom_byte),
		.last_byte (last_byte),
		.q_full    (q_stat.full),
		.push      (push),
		.push_beat (push_beat),
		.stat      (f_stat)
	);

	rilp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.pop       (pop),
		.head_beat (head_beat),
		.stat      (q_stat)
	);

	rilp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_beat     (head_beat),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_data    (write_data),
		.image_done    (image_done),
		.status        (status)
	);

	`RILP_ASSERT_NEVER(a_q_full_empty, q_stat.full && q_stat.empty, "queue full and empty")
	`RILP_ASSERT_IMPLY(a_out_nonempty, out_valid, write_valid || image_done, "empty result beat")
	`RILP_ASSERT_IMPLY(a_status_done, out_valid && status, image_done, "status without done")
	`RILP_ASSERT_NEXT(a_last_resets, in_valid && !in_stall && last_byte,
		f_stat.phase == rilp_pkg::PH_HDR1 && !f_stat.err, "parser not reset after last byte")

endmodule

// File: tb/tb.sv
// testbench for rom_image_loader_parser: random and directed rom images with a byte predictor
// depends on rilp_pkg and the rom_image_loader_parser top level
module tb;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
	} rom_item_t;

	localparam logic [7:0] IMAGE_MAGIC [4] = '{8'hff, 8'hfe, 8'hfe, 8'hff};
	localparam logic [7:0] TYPE_END = 8'h00;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rom_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        write_valid;
	logic [15:0] write_address;
	logic [7:0]  write_data;
	logic        image_done;
	logic        status;

	rom_image_loader_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rom_byte(rom_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_valid(write_valid),
		.write_address(write_address),
		.write_data(write_data),
		.image_done(image_done),
		.status(status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rom_item_t         image_bytes[$];
	rilp_pkg::beat_t   load_results[$];
	logic [7:0]        img_buf[$];
	int                bytes_queued = 0;
	int                load_errors = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	logic              pressure_req = 1'b0;
	logic              holding = 1'b0;
	rom_item_t         next_item;
	rilp_pkg::beat_t   want;

	// loader state
	rilp_pkg::phase_t  ld_phase = rilp_pkg::PH_HDR1;
	logic [1:0]        hdr_pos = 2'd0;
	logic [7:0]        addr_hi = 8'h00;
	logic [15:0]       cur_addr = 16'h0000;
	logic              bad_image = 1'b0;

	function automatic void parse_byte(input logic [7:0] b, input logic lst);
		rilp_pkg::beat_t r;
		logic ok_end;
		r = '0;
		ok_end = 1'b0;
		case (ld_phase)
			rilp_pkg::PH_HDR1, rilp_pkg::PH_HDR2: begin
				if (b != IMAGE_MAGIC[hdr_pos]) begin
					bad_image = 1'b1;
					ld_phase = rilp_pkg::PH_DRAIN;
				end else if (hdr_pos == rilp_pkg::HDR_LAST) begin
					hdr_pos = 2'd0;
					ld_phase = (ld_phase == rilp_pkg::PH_HDR1) ? rilp_pkg::PH_SECT1
						: rilp_pkg::PH_SECT2;
				end else begin
					hdr_pos = hdr_pos + 2'd1;
				end
			end
			rilp_pkg::PH_SECT1: begin
				if (b == rilp_pkg::SEC_DATA)
					ld_phase = rilp_pkg::PH_DADDR_HI;
				else if (b == rilp_pkg::SEC_CODE)
					ld_phase = rilp_pkg::PH_CADDR_HI;
				else begin
					bad_image = 1'b1;
					ld_phase = rilp_pkg::PH_DRAIN;
				end
			end
			rilp_pkg::PH_DADDR_HI: begin
				addr_hi = b;
				ld_phase = rilp_pkg::PH_DADDR_LO;
			end
			rilp_pkg::PH_DADDR_LO: begin
				cur_addr = {addr_hi, b};
				ld_phase = rilp_pkg::PH_DTYPE;
			end
			rilp_pkg::PH_DTYPE: begin
				if (b == rilp_pkg::TYPE_NUM)
					ld_phase = rilp_pkg::PH_DNUM;
				else if (b == rilp_pkg::TYPE_STR)
					ld_phase = rilp_pkg::PH_DSTR;
				else begin
					hdr_pos = 2'd0;
					ld_phase = rilp_pkg::PH_HDR2;
				end
			end
			rilp_pkg::PH_DNUM: begin
				r.wr = 1'b1;
				r.addr = cur_addr;
				r.data = b;
				ld_phase = rilp_pkg::PH_DADDR_HI;
			end
			rilp_pkg::PH_DSTR: begin
				if (b == rilp_pkg::STR_END) begin
					ld_phase = rilp_pkg::PH_DADDR_HI;
				end else if (!lst) begin
					r.wr = 1'b1;
					r.addr = cur_addr;
					r.data = b;
					cur_addr = cur_addr + 16'd1;
				end
			end
			rilp_pkg::PH_SECT2: begin
				if (b == rilp_pkg::SEC_CODE)
					ld_phase = rilp_pkg::PH_CADDR_HI;
				else begin
					bad_image = 1'b1;
					ld_phase = rilp_pkg::PH_DRAIN;
				end
			end
			rilp_pkg::PH_CADDR_HI: begin
				addr_hi = b;
				ld_phase = rilp_pkg::PH_CADDR_LO;
			end
			rilp_pkg::PH_CADDR_LO: begin
				cur_addr = {addr_hi, b};
				ld_phase = rilp_pkg::PH_CBODY;
				ok_end = 1'b1;
			end
			rilp_pkg::PH_CBODY: begin
				r.wr = 1'b1;
				r.addr = cur_addr;
				r.data = b;
				cur_addr = cur_addr + 16'd1;
				ok_end = 1'b1;
			end
			default: begin
				bad_image = 1'b1;
				ld_phase = rilp_pkg::PH_DRAIN;
			end
		endcase
		if (r.wr || lst) begin
			r.done = lst;
			r.err = lst && !(ok_end && !bad_image);
			load_results.push_back(r);
		end
		if (lst) begin
			ld_phase = rilp_pkg::PH_HDR1;
			hdr_pos = 2'd0;
			addr_hi = 8'h00;
			cur_addr = 16'h0000;
			bad_image = 1'b0;
		end
	endfunction

	function automatic void send_image();
		rom_item_t it;
		foreach (img_buf[i]) begin
			it.b = img_buf[i];
			it.lst = (i == img_buf.size() - 1);
			image_bytes.push_back(it);
		end
		bytes_queued += img_buf.size();
	endfunction

	function automatic void add_header();
		foreach (IMAGE_MAGIC[i])
			img_buf.push_back(IMAGE_MAGIC[i]);
	endfunction

	function automatic void add_addr();
		logic [15:0] a;
		// lean on the top of memory so writes wrap
		a = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hfff0, 16'hffff)) : 16'($urandom);
		img_buf.push_back(a[15:8]);
		img_buf.push_back(a[7:0]);
	endfunction

	function automatic void queue_image();
		int kind;
		int len;
		int cut;
		int idx;
		img_buf.delete();
		kind = $urandom_range(99);
		if (kind < 6) begin
			repeat ($urandom_range(1, 12))
				img_buf.push_back(8'($urandom));
		end else begin
			add_header();
			if ($urandom_range(2) != 0) begin
				img_buf.push_back(rilp_pkg::SEC_DATA);
				repeat ($urandom_range(4)) begin
					add_addr();
					if ($urandom_range(1) == 0) begin
						img_buf.push_back(rilp_pkg::TYPE_NUM);
						img_buf.push_back(8'($urandom));
					end else begin
						img_buf.push_back(rilp_pkg::TYPE_STR);
						repeat ($urandom_range(5))
							img_buf.push_back(8'($urandom_range(1, 255)));
						img_buf.push_back(rilp_pkg::STR_END);
					end
				end
				add_addr();
				img_buf.push_back(($urandom_range(1) == 0) ? TYPE_END : 8'($urandom_range(3, 255)));
				add_header();
			end
			img_buf.push_back(rilp_pkg::SEC_CODE);
			add_addr();
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
			repeat (len)
				img_buf.push_back(8'($urandom));
			if (kind < 20) begin
				idx = $urandom_range(img_buf.size() - 1);
				img_buf[idx] = 8'($urandom);
			end else if (kind < 34) begin
				cut = $urandom_range(1, img_buf.size());
				while (img_buf.size() > cut)
					void'(img_buf.pop_back());
			end
		end
		send_image();
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (image_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = image_bytes.pop_front();
				parse_byte(next_item.b, next_item.lst);
				in_valid <= 1'b1;
				rom_byte <= next_item.b;
				last_byte <= next_item.lst;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (load_results.size() == 0) begin
					$error("unexpected beat: write_address %h write_data %h", write_address,
						write_data);
					load_errors++;
				end else begin
					want = load_results.pop_front();
					if (write_valid !== want.wr) begin
						$error("write_valid: expected %0d, got %0d", want.wr, write_valid);
						load_errors++;
					end
					if (write_address !== want.addr) begin
						$error("write_address: expected %h, got %h", want.addr, write_address);
						load_errors++;
					end
					if (write_data !== want.data) begin
						$error("write_data: expected %h, got %h", want.data, write_data);
						load_errors++;
					end
					if (image_done !== want.done) begin
						$error("image_done: expected %0d, got %0d", want.done, image_done);
						load_errors++;
					end
					if (status !== want.err) begin
						$error("status: expected %0d, got %0d", want.err, status);
						load_errors++;
					end
				end
			end
			out_stall <= holding || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// long receiver hold-off so the input side backs up
	initial begin
		wait (pressure_req);
		@(posedge clk);
		holding <= 1'b1;
		repeat (400) @(posedge clk);
		holding <= 1'b0;
	end

	initial begin
		#400000;
		$display("rom_image_loader_parser test failed");
		$finish;
	end

	initial begin
		int send_pcts[4];
		int stall_pcts[4];
		int target;
		send_pcts = '{0, 57, 0, 17};
		stall_pcts = '{0, 0, 57, 17};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full image with string wrap, unknown end type and a code byte at the top
		img_buf = '{8'hff, 8'hfe, 8'hfe, 8'hff, rilp_pkg::SEC_DATA,
			8'hff, 8'hff, rilp_pkg::TYPE_STR, 8'h41, rilp_pkg::STR_END,
			8'h00, 8'h00, rilp_pkg::TYPE_NUM, 8'hff,
			8'h00, 8'h00, 8'h07,
			8'hff, 8'hfe, 8'hfe, 8'hff, rilp_pkg::SEC_CODE,
			8'hff, 8'hff, 8'h7f};
		send_image();
		img_buf = '{8'hfe};
		send_image();
		while (image_bytes.size() != 0) @(negedge clk);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			recv_stall_pct = stall_pcts[p];
			target = bytes_queued + 400;
			while (bytes_queued < target)
				queue_image();
			while (image_bytes.size() != 0) @(negedge clk);
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_req = 1'b1;
		target = bytes_queued + 250;
		while (bytes_queued < target)
			queue_image();
		while (image_bytes.size() != 0 || in_valid) @(negedge clk);
		while (load_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		if (load_errors == 0 && load_results.size() == 0) begin
			$display("rom_image_loader_parser test passed");
		end else begin
			$display("rom_image_loader_parser test failed");
		end
		$finish;
	end

endmodule
